// ----- src/rtnb_pkg.sv -----
// ----------------------------------------------------------------------------
// rtnb_pkg
// Shared types, constants and helpers for the radix tree node builder.
// ----------------------------------------------------------------------------
package rtnb_pkg;

	// Store depth and derived widths
	localparam int LEAVES_MAX = 1024;
	localparam int ADDR_W     = $clog2(LEAVES_MAX);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int KEY_W      = 64;
	// search offsets and signed positions
	localparam int OFF_W      = ADDR_W + 3;
	localparam int POS_W      = ADDR_W + 4;
	// prefix length -1..64, signed
	localparam int PFX_W      = 8;

	// Upper-bound search: the bound starts here and is scaled by four before each probe
	localparam int FIRST_BOUND = 32;
	localparam logic [OFF_W-1:0] FIRST_PROBE = OFF_W'(FIRST_BOUND * 4);

	localparam logic signed [PFX_W-1:0] PFX_NONE = -8'sd1;

	localparam logic [CNT_W-1:0] LEAVES_MIN_N = CNT_W'(2);
	localparam logic [CNT_W-1:0] LEAVES_MAX_N = CNT_W'(LEAVES_MAX);

	// Command codes carried on s_tuser
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_BUILD = 1'b1;

	// Request payload, position in the lowest bits
	localparam int S_TDATA_W = 80;
	typedef struct packed {
		logic [S_TDATA_W-KEY_W-ADDR_W-1:0] pad;
		logic [KEY_W-1:0]                  key_value;
		logic [ADDR_W-1:0]                 position;
	} in_req_t;

	// Result payload, node_index in the lowest bits
	localparam int M_TDATA_W = 56;
	typedef struct packed {
		logic [M_TDATA_W-5*ADDR_W-2-1:0] pad;
		logic [ADDR_W-1:0]               range_high;
		logic [ADDR_W-1:0]               range_low;
		logic                            right_is_leaf;
		logic [ADDR_W-1:0]               right_child;
		logic                            left_is_leaf;
		logic [ADDR_W-1:0]               left_child;
		logic [ADDR_W-1:0]               node_index;
	} out_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NBR0,
		ST_NBR1,
		ST_NBR2,
		ST_UP_RD,
		ST_UP_EV,
		ST_LEN_RD,
		ST_LEN_EV,
		ST_PN_EV,
		ST_SPL_RD,
		ST_SPL_EV,
		ST_DONE
	} state_t;

	// Leading-zero count of a 64-bit word: per-byte counts, then first nonzero byte
	function automatic logic [6:0] lead_zeros(input logic [KEY_W-1:0] x);
		logic [7:0] grp;
		logic [2:0] gcnt [8];
		logic [7:0] gnz;
		logic [6:0] res;
		res = 7'd64;
		for (int g = 0; g < 8; g++) begin
			grp     = x[KEY_W-1-8*g -: 8];
			gnz[g]  = |grp;
			gcnt[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (grp[b])
					gcnt[g] = 3'(7 - b);
			end
		end
		for (int g = 7; g >= 0; g--) begin
			if (gnz[g])
				res = {1'b0, 3'(g), gcnt[g]};
		end
		return res;
	endfunction

endpackage

// ----- src/rtnb_ram.sv -----
// ----------------------------------------------------------------------------
// rtnb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtnb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- src/radix_tree_node_builder.sv -----
// ----------------------------------------------------------------------------
// radix_tree_node_builder
// Binary radix tree internal node builder over a store of sorted 64-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) carries requests.
//   s_tuser = 0 stores key_value at index position; no result is returned.
//   s_tuser = 1 builds internal node position; one result follows on the master
//   channel (m_tvalid/m_tready/m_tdata). A build with position >= n-1 is
//   dropped without a result. cfg_wr_en/cfg_wr_data set the leaf count n; the user
//   must write it only while the block is idle, which the block does not enforce.
// Operation:
//   A build runs one key-store read per step through a single read port:
//   three neighbor reads, one to three bound probes, a length search of
//   seven to eleven probes and a split search of one to ten. An in-range
//   probe reads in one state and then compares in an evaluate state; an
//   out-of-range probe is decided in the read state alone. The result is
//   registered in the done state; the next request is taken back in idle.
// Reset:
//   arst_n clears control state and sets n to 2. Key store contents stay
//   undefined until written.
// Stall:
//   The finished result waits in an output register; the next request is
//   taken meanwhile, and a second result waits in the done state until the
//   register frees up.
// ----------------------------------------------------------------------------
module radix_tree_node_builder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rtnb_pkg::CNT_W-1:0]      cfg_wr_data,   // leaf_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rtnb_pkg::S_TDATA_W-1:0]  s_tdata,       // position, key_value
	input  logic                            s_tuser,       // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rtnb_pkg::M_TDATA_W-1:0]  m_tdata        // node_index, left_child,
	                                                       // left_is_leaf, right_child,
	                                                       // right_is_leaf, range_low,
	                                                       // range_high
);

	import rtnb_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]        n_eff_q;
	logic [ADDR_W-1:0]       node_q;
	logic [KEY_W-1:0]        base_q;
	logic signed [PFX_W-1:0] prev_q, pmin_q, pnode_q;
	logic                    dir_neg_q;
	logic [OFF_W-1:0]        lmax_q, l_q, t_q, s_q;
	logic signed [POS_W-1:0] j_q;
	logic                    out_valid_q;
	out_res_t                out_data_q;

	in_req_t                 in_req;
	logic                    accept, build_ok, out_free, load_out;
	logic                    ram_wr_en;
	logic [ADDR_W-1:0]       ram_rd_addr;
	logic [KEY_W-1:0]        ram_rd_data;
	logic [6:0]              cp;
	logic signed [PFX_W-1:0] cp_s, pmin_new;
	logic                    hit_pmin, hit_pnode;
	logic [OFF_W:0]          t_sum;
	logic [OFF_W-1:0]        t_half;
	logic [OFF_W-1:0]        probe_off;
	logic signed [POS_W-1:0] node_s, off_s, probe_pos;
	logic                    in_range;
	logic signed [POS_W-1:0] k_pos, k1_pos, lo_pos, hi_pos;
	out_res_t                res;

	// Request decode
	assign in_req   = in_req_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign build_ok = ({1'b0, in_req.position} + CNT_W'(1)) < n_eff_q;
	assign out_free = !out_valid_q || m_tready;
	assign load_out = (state_q == ST_DONE) && out_free;

	// Key store
	rtnb_ram #(
		.WIDTH (KEY_W),
		.DEPTH (LEAVES_MAX)
	) u_key_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (in_req.position),
		.wr_data (in_req.key_value),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Prefix length against the base key and the search compares
	assign cp        = lead_zeros(base_q ^ ram_rd_data);
	assign cp_s      = signed'({1'b0, cp});
	assign hit_pmin  = cp_s > pmin_q;
	assign hit_pnode = cp_s > pnode_q;
	assign pmin_new  = (prev_q < cp_s) ? prev_q : cp_s;

	// Split step size: ceil(t / 2)
	assign t_sum  = {1'b0, t_q} + (OFF_W+1)'(1);
	assign t_half = t_sum[OFF_W:1];

	// Probe position i +/- offset and its range check
	always_comb begin
		case (state_q)
			ST_UP_RD:  probe_off = lmax_q;
			ST_LEN_RD: probe_off = l_q + t_q;
			ST_SPL_RD: probe_off = s_q + t_half;
			ST_DONE:   probe_off = s_q;
			default:   probe_off = '0;
		endcase
	end

	assign node_s    = signed'({{(POS_W-ADDR_W){1'b0}}, node_q});
	assign off_s     = signed'({{(POS_W-OFF_W){1'b0}}, probe_off});
	assign probe_pos = dir_neg_q ? (node_s - off_s) : (node_s + off_s);
	assign in_range  = !probe_pos[POS_W-1] &&
	                   (probe_pos[POS_W-2:0] < {{(POS_W-1-CNT_W){1'b0}}, n_eff_q});

	// Result fields
	assign k_pos  = probe_pos - POS_W'(dir_neg_q);
	assign k1_pos = k_pos + POS_W'(1);
	assign lo_pos = (j_q < node_s) ? j_q : node_s;
	assign hi_pos = (j_q < node_s) ? node_s : j_q;

	always_comb begin
		res               = '0;
		res.node_index    = node_q;
		res.left_child    = k_pos[ADDR_W-1:0];
		res.left_is_leaf  = (lo_pos == k_pos);
		res.right_child   = k1_pos[ADDR_W-1:0];
		res.right_is_leaf = (hi_pos == k1_pos);
		res.range_low     = lo_pos[ADDR_W-1:0];
		res.range_high    = hi_pos[ADDR_W-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && s_tuser == CMD_BUILD && build_ok) state_d = ST_NBR0;
			ST_NBR0:   state_d = ST_NBR1;
			ST_NBR1:   state_d = ST_NBR2;
			ST_NBR2:   state_d = ST_UP_RD;
			ST_UP_RD:  state_d = in_range ? ST_UP_EV : ST_LEN_RD;
			ST_UP_EV:  state_d = hit_pmin ? ST_UP_RD : ST_LEN_RD;
			ST_LEN_RD: begin
				if (t_q == '0)
					state_d = ST_PN_EV;
				else if (in_range)
					state_d = ST_LEN_EV;
			end
			ST_LEN_EV: state_d = ST_LEN_RD;
			ST_PN_EV:  state_d = ST_SPL_RD;
			ST_SPL_RD: begin
				if (in_range)
					state_d = ST_SPL_EV;
				else if (t_half <= OFF_W'(1))
					state_d = ST_DONE;
			end
			ST_SPL_EV: state_d = (t_q > OFF_W'(1)) ? ST_SPL_RD : ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		ram_wr_en = accept && (s_tuser == CMD_STORE);
		unique case (state_q)
			ST_IDLE: ram_rd_addr = in_req.position;
			ST_NBR0: ram_rd_addr = node_q - ADDR_W'(1);
			ST_NBR1: ram_rd_addr = node_q + ADDR_W'(1);
			default: ram_rd_addr = probe_pos[ADDR_W-1:0];
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_eff_q     <= LEAVES_MIN_N;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				if (cfg_wr_data < LEAVES_MIN_N)
					n_eff_q <= LEAVES_MIN_N;
				else if (cfg_wr_data > LEAVES_MAX_N)
					n_eff_q <= LEAVES_MAX_N;
				else
					n_eff_q <= cfg_wr_data;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) node_q <= in_req.position;
			ST_NBR0: base_q <= ram_rd_data;
			ST_NBR1: prev_q <= (node_q == '0) ? PFX_NONE : cp_s;
			ST_NBR2: begin
				pmin_q    <= pmin_new;
				dir_neg_q <= !(cp_s > prev_q);
				lmax_q    <= FIRST_PROBE;
			end
			ST_UP_RD: begin
				if (!in_range) begin
					l_q <= '0;
					t_q <= lmax_q >> 1;
				end
			end
			ST_UP_EV: begin
				if (hit_pmin) begin
					lmax_q <= lmax_q << 2;
				end else begin
					l_q <= '0;
					t_q <= lmax_q >> 1;
				end
			end
			ST_LEN_RD: begin
				if (t_q == '0)
					j_q <= probe_pos;
				else if (!in_range)
					t_q <= t_q >> 1;
			end
			ST_LEN_EV: begin
				if (hit_pmin)
					l_q <= l_q + t_q;
				t_q <= t_q >> 1;
			end
			ST_PN_EV: begin
				pnode_q <= cp_s;
				s_q     <= '0;
				t_q     <= l_q;
			end
			ST_SPL_RD: t_q <= t_half;
			ST_SPL_EV: if (hit_pnode) s_q <= s_q + t_q;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- src/rtnb_checker.sv -----
// ----------------------------------------------------------------------------
// rtnb_checker
// Port-level checks for the radix tree node builder, bound to the top level.
// ----------------------------------------------------------------------------
module rtnb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rtnb_pkg::M_TDATA_W-1:0]  m_tdata
);

	import rtnb_pkg::*;

	out_res_t res;
	assign res = out_res_t'(m_tdata);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Covered range is ordered
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.range_low <= res.range_high)
		else $error("range_low above range_high");

	// The node sits at one end of its range
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.node_index == res.range_low) || (res.node_index == res.range_high))
		else $error("node index not at a range end");

	// Children are adjacent
	a_child: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.right_child == res.left_child + ADDR_W'(1))
		else $error("right child does not follow left child");

	// A store request never produces a result
	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_STORE) && !m_tvalid |=> !m_tvalid)
		else $error("result after a store request");

endmodule

bind radix_tree_node_builder rtnb_checker u_rtnb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
